// ----- hw/rtl/fhmc_pkg.sv -----
// types, constants and codes shared by the mutex and condition variable lock manager
package fhmc_pkg;

    localparam int THREAD_BITS    = 6;
    localparam int MQ_DEPTH       = 16;
    localparam int CQ_DEPTH       = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int REQ_FIFO_DEPTH = 2;
    localparam int SPIN_BITS      = 10;
    localparam int OP_BITS        = 3;
    localparam int CFG_IDX_BITS   = 1;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 32;

    typedef logic [THREAD_BITS-1:0] tid_t;
    typedef logic [SPIN_BITS-1:0]   spin_t;

    localparam spin_t SPIN_RESET         = 10'd64;
    localparam spin_t SPIN_FLOOR_RESET   = 10'd16;
    localparam spin_t SPIN_CEILING_RESET = 10'd512;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPIN_FLOOR   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPIN_CEILING = 1'b1;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOCK     = 3'd0,
        OP_UNLOCK   = 3'd1,
        OP_TRY      = 3'd2,
        OP_WAIT     = 3'd3,
        OP_WAKE_ONE = 3'd4,
        OP_WAKE_ALL = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        K_LOCK,
        K_UNLOCK,
        K_TRY,
        K_WAIT,
        K_WAKE_ONE,
        K_WAKE_ALL,
        K_BAD
    } req_kind_t;

    typedef enum logic [2:0] {
        ACT_GRANTED = 3'd0,
        ACT_QMUTEX  = 3'd1,
        ACT_QCOND   = 3'd2,
        ACT_FREED   = 3'd3,
        ACT_NOBODY  = 3'd4,
        ACT_BUSY    = 3'd5,
        ACT_REJECT  = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK               = 2'd0,
        STAT_UNLOCK_NOT_OWNER = 2'd1,
        STAT_WAIT_NOT_OWNER   = 2'd2,
        STAT_FULL             = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RELEASE,
        S_WAKE
    } state_t;

    typedef struct packed {
        req_kind_t kind;
        tid_t      tid;
    } req_t;

    typedef struct packed {
        spin_t spin_floor;
        spin_t spin_ceiling;
    } cfg_t;

    // packed from the lowest bit: subject, action, owner valid, owner, spin hint, status
    typedef struct packed {
        status_t status;
        spin_t   spin_hint;
        tid_t    owner_thread;
        logic    owner_valid;
        action_t action;
        tid_t    subject_thread;
    } res_t;

    localparam int IN_PAD_W  = IN_TDATA_W - OP_BITS - THREAD_BITS;
    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(res_t);

endpackage

// ----- hw/rtl/fhmc_front.sv -----
// front stage: accepts requests and decodes the op into a request kind
module fhmc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fhmc_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                         push,
    output fhmc_pkg::req_t               push_req,
    input  logic                         fifo_full
);

    logic             valid_reg;
    logic             valid_next;
    fhmc_pkg::req_t   req_reg;
    fhmc_pkg::req_t   req_next;
    logic [fhmc_pkg::OP_BITS-1:0] op_in;
    fhmc_pkg::tid_t   tid_in;
    logic             accept;

    assign op_in    = s_tdata[fhmc_pkg::OP_BITS-1:0];
    assign tid_in   = s_tdata[fhmc_pkg::OP_BITS +: fhmc_pkg::THREAD_BITS];
    assign push     = valid_reg && !fifo_full;
    assign s_tready = !valid_reg || !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign push_req = req_reg;

    always_comb begin
        req_next     = req_reg;
        valid_next   = valid_reg;
        if (accept) begin
            valid_next   = 1'b1;
            req_next.tid = tid_in;
            case (op_in)
                fhmc_pkg::OP_LOCK:     req_next.kind = fhmc_pkg::K_LOCK;
                fhmc_pkg::OP_UNLOCK:   req_next.kind = fhmc_pkg::K_UNLOCK;
                fhmc_pkg::OP_TRY:      req_next.kind = fhmc_pkg::K_TRY;
                fhmc_pkg::OP_WAIT:     req_next.kind = fhmc_pkg::K_WAIT;
                fhmc_pkg::OP_WAKE_ONE: req_next.kind = fhmc_pkg::K_WAKE_ONE;
                fhmc_pkg::OP_WAKE_ALL: req_next.kind = fhmc_pkg::K_WAKE_ALL;
                default:               req_next.kind = fhmc_pkg::K_BAD;
            endcase
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

endmodule

// ----- hw/rtl/fhmc_req_fifo.sv -----
// short request queue between the decode front and the execution back
module fhmc_req_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fhmc_pkg::req_t push_req,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output fhmc_pkg::req_t head_req
);

    localparam int AW = $clog2(fhmc_pkg::REQ_FIFO_DEPTH);
    localparam int CW = $clog2(fhmc_pkg::REQ_FIFO_DEPTH + 1);

    fhmc_pkg::req_t mem [fhmc_pkg::REQ_FIFO_DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full       = (count_reg == CW'(fhmc_pkg::REQ_FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(fhmc_pkg::REQ_FIFO_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(fhmc_pkg::REQ_FIFO_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ----- hw/rtl/fhmc_back.sv -----
// execution back end: mutex and condition state, waiter queues and the result register
module fhmc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  fhmc_pkg::cfg_t cfg,
    input  logic           head_valid,
    input  fhmc_pkg::req_t head_req,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output fhmc_pkg::res_t m_res,
    output logic           m_tlast
);

    localparam int MAW = $clog2(fhmc_pkg::MQ_DEPTH);
    localparam int MCW = $clog2(fhmc_pkg::MQ_DEPTH + 1);
    localparam int CAW = $clog2(fhmc_pkg::CQ_DEPTH);
    localparam int CCW = $clog2(fhmc_pkg::CQ_DEPTH + 1);
    localparam int NW  = $clog2(fhmc_pkg::MAX_RESULTS + 1);

    fhmc_pkg::tid_t   mq_mem [fhmc_pkg::MQ_DEPTH];
    fhmc_pkg::tid_t   cq_mem [fhmc_pkg::CQ_DEPTH];

    fhmc_pkg::state_t state_reg, state_next;
    logic             owner_present_reg, owner_present_next;
    fhmc_pkg::tid_t   owner_id_reg, owner_id_next;
    fhmc_pkg::spin_t  spin_reg, spin_next;
    logic [MAW-1:0]   mq_head_reg, mq_head_next;
    logic [MCW-1:0]   mq_count_reg, mq_count_next;
    logic [CAW-1:0]   cq_head_reg, cq_head_next;
    logic [CCW-1:0]   cq_count_reg, cq_count_next;
    logic [NW-1:0]    n_reg, n_next;
    fhmc_pkg::tid_t   req_tid_reg, req_tid_next;
    logic             m_valid_reg, m_valid_next;
    fhmc_pkg::res_t   m_res_reg, m_res_next;
    logic             m_last_reg, m_last_next;

    logic             out_free;
    logic             is_owner;
    logic             mq_full;
    logic             cq_full;
    logic [MAW:0]     mq_sum;
    logic [MAW-1:0]   mq_tail;
    logic [CAW:0]     cq_sum;
    logic [CAW-1:0]   cq_tail;
    fhmc_pkg::tid_t   cq_head_tid;
    fhmc_pkg::tid_t   mq_head_tid;

    fhmc_pkg::tid_t     acq_tid;
    fhmc_pkg::action_t  acq_act;
    fhmc_pkg::status_t  acq_st;
    logic               acq_grant;
    logic               acq_queue;
    fhmc_pkg::tid_t     rel_tid;
    logic               rel_handoff;

    logic               do_acq;
    logic               do_rel;
    logic               try_grant;
    logic               cq_push;
    logic               cq_pop;
    logic               out_load;
    fhmc_pkg::tid_t     o_subj;
    fhmc_pkg::action_t  o_act;
    fhmc_pkg::status_t  o_st;
    logic               o_last;
    logic               wake_ok;

    assign out_free    = !m_valid_reg || m_tready;
    assign is_owner    = owner_present_reg && (owner_id_reg == head_req.tid);
    assign mq_full     = (mq_count_reg >= MCW'(fhmc_pkg::MQ_DEPTH));
    assign cq_full     = (cq_count_reg >= CCW'(fhmc_pkg::CQ_DEPTH));
    assign mq_sum      = (MAW+1)'(mq_head_reg) + (MAW+1)'(mq_count_reg);
    assign mq_tail     = (mq_sum >= (MAW+1)'(fhmc_pkg::MQ_DEPTH))
                         ? MAW'(mq_sum - (MAW+1)'(fhmc_pkg::MQ_DEPTH)) : MAW'(mq_sum);
    assign cq_sum      = (CAW+1)'(cq_head_reg) + (CAW+1)'(cq_count_reg);
    assign cq_tail     = (cq_sum >= (CAW+1)'(fhmc_pkg::CQ_DEPTH))
                         ? CAW'(cq_sum - (CAW+1)'(fhmc_pkg::CQ_DEPTH)) : CAW'(cq_sum);
    assign cq_head_tid = cq_mem[cq_head_reg];
    assign mq_head_tid = mq_mem[mq_head_reg];

    // lock on behalf of one thread: grant, queue or full
    assign acq_tid = (state_reg == fhmc_pkg::S_WAKE ||
                      head_req.kind == fhmc_pkg::K_WAKE_ONE ||
                      head_req.kind == fhmc_pkg::K_WAKE_ALL) ? cq_head_tid : head_req.tid;

    always_comb begin
        acq_grant = 1'b0;
        acq_queue = 1'b0;
        acq_act   = fhmc_pkg::ACT_GRANTED;
        acq_st    = fhmc_pkg::STAT_OK;
        if (!owner_present_reg) begin
            acq_grant = 1'b1;
        end else if (mq_full) begin
            acq_act = fhmc_pkg::ACT_REJECT;
            acq_st  = fhmc_pkg::STAT_FULL;
        end else begin
            acq_queue = 1'b1;
            acq_act   = fhmc_pkg::ACT_QMUTEX;
        end
    end

    assign wake_ok     = (acq_act != fhmc_pkg::ACT_REJECT);
    assign rel_tid     = (state_reg == fhmc_pkg::S_RELEASE) ? req_tid_reg : head_req.tid;
    assign rel_handoff = (mq_count_reg != '0);

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        req_tid_next = req_tid_reg;
        pop          = 1'b0;
        do_acq       = 1'b0;
        do_rel       = 1'b0;
        try_grant    = 1'b0;
        cq_push      = 1'b0;
        cq_pop       = 1'b0;
        out_load     = 1'b0;
        o_subj       = head_req.tid;
        o_act        = fhmc_pkg::ACT_REJECT;
        o_st         = fhmc_pkg::STAT_OK;
        o_last       = 1'b1;
        case (state_reg)
            fhmc_pkg::S_IDLE: begin
                if (head_valid && out_free) begin
                    pop      = 1'b1;
                    out_load = 1'b1;
                    case (head_req.kind)
                        fhmc_pkg::K_LOCK: begin
                            do_acq = 1'b1;
                            o_act  = acq_act;
                            o_st   = acq_st;
                        end
                        fhmc_pkg::K_UNLOCK: begin
                            if (!is_owner) begin
                                o_st = fhmc_pkg::STAT_UNLOCK_NOT_OWNER;
                            end else begin
                                do_rel = 1'b1;
                                o_subj = rel_handoff ? mq_head_tid : rel_tid;
                                o_act  = rel_handoff ? fhmc_pkg::ACT_GRANTED
                                                     : fhmc_pkg::ACT_FREED;
                            end
                        end
                        fhmc_pkg::K_TRY: begin
                            if (!owner_present_reg) begin
                                try_grant = 1'b1;
                                o_act     = fhmc_pkg::ACT_GRANTED;
                            end else begin
                                o_act = fhmc_pkg::ACT_BUSY;
                            end
                        end
                        fhmc_pkg::K_WAIT: begin
                            if (!is_owner) begin
                                o_st = fhmc_pkg::STAT_WAIT_NOT_OWNER;
                            end else if (cq_full) begin
                                o_st = fhmc_pkg::STAT_FULL;
                            end else begin
                                cq_push      = 1'b1;
                                o_act        = fhmc_pkg::ACT_QCOND;
                                o_last       = 1'b0;
                                req_tid_next = head_req.tid;
                                state_next   = fhmc_pkg::S_RELEASE;
                            end
                        end
                        fhmc_pkg::K_WAKE_ONE, fhmc_pkg::K_WAKE_ALL: begin
                            if (cq_count_reg == '0) begin
                                o_act = fhmc_pkg::ACT_NOBODY;
                            end else begin
                                do_acq = 1'b1;
                                cq_pop = wake_ok;
                                o_subj = acq_tid;
                                o_act  = acq_act;
                                o_st   = acq_st;
                                n_next = NW'(1);
                                if (head_req.kind == fhmc_pkg::K_WAKE_ALL && wake_ok &&
                                    cq_count_reg > CCW'(1) && fhmc_pkg::MAX_RESULTS > 1) begin
                                    o_last     = 1'b0;
                                    state_next = fhmc_pkg::S_WAKE;
                                end
                            end
                        end
                        default: begin
                            o_st = fhmc_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            fhmc_pkg::S_RELEASE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    do_rel     = 1'b1;
                    o_subj     = rel_handoff ? mq_head_tid : rel_tid;
                    o_act      = rel_handoff ? fhmc_pkg::ACT_GRANTED : fhmc_pkg::ACT_FREED;
                    state_next = fhmc_pkg::S_IDLE;
                end
            end
            fhmc_pkg::S_WAKE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    do_acq   = 1'b1;
                    cq_pop   = wake_ok;
                    o_subj   = acq_tid;
                    o_act    = acq_act;
                    o_st     = acq_st;
                    n_next   = n_reg + 1'b1;
                    if (wake_ok && cq_count_reg > CCW'(1) &&
                        (n_reg + 1'b1) < NW'(fhmc_pkg::MAX_RESULTS)) begin
                        o_last = 1'b0;
                    end else begin
                        state_next = fhmc_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = fhmc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        owner_present_next = owner_present_reg;
        owner_id_next      = owner_id_reg;
        spin_next          = spin_reg;
        mq_head_next       = mq_head_reg;
        mq_count_next      = mq_count_reg;
        cq_head_next       = cq_head_reg;
        cq_count_next      = cq_count_reg;
        if (do_acq && acq_grant) begin
            owner_present_next = 1'b1;
            owner_id_next      = acq_tid;
            if (spin_reg < cfg.spin_ceiling) begin
                spin_next = spin_reg + 1'b1;
            end
        end
        if (do_acq && acq_queue) begin
            mq_count_next = mq_count_reg + 1'b1;
            if (spin_reg > cfg.spin_floor) begin
                spin_next = spin_reg - 1'b1;
            end
        end
        if (do_rel) begin
            if (rel_handoff) begin
                owner_present_next = 1'b1;
                owner_id_next      = mq_head_tid;
                mq_count_next      = mq_count_reg - 1'b1;
                mq_head_next       = (mq_head_reg == MAW'(fhmc_pkg::MQ_DEPTH - 1)) ? '0
                                                                                   : mq_head_reg + 1'b1;
            end else begin
                owner_present_next = 1'b0;
                owner_id_next      = '0;
            end
        end
        if (try_grant) begin
            owner_present_next = 1'b1;
            owner_id_next      = head_req.tid;
        end
        if (cq_push) begin
            cq_count_next = cq_count_reg + 1'b1;
        end
        if (cq_pop) begin
            cq_count_next = cq_count_reg - 1'b1;
            cq_head_next  = (cq_head_reg == CAW'(fhmc_pkg::CQ_DEPTH - 1)) ? '0
                                                                          : cq_head_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        m_last_next  = m_last_reg;
        if (out_load) begin
            m_valid_next              = 1'b1;
            m_last_next               = o_last;
            m_res_next.subject_thread = o_subj;
            m_res_next.action         = o_act;
            m_res_next.status         = o_st;
            m_res_next.owner_valid    = owner_present_next;
            m_res_next.owner_thread   = owner_present_next ? owner_id_next : '0;
            m_res_next.spin_hint      = spin_next;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= fhmc_pkg::S_IDLE;
            owner_present_reg <= 1'b0;
            owner_id_reg      <= '0;
            spin_reg          <= fhmc_pkg::SPIN_RESET;
            mq_head_reg       <= '0;
            mq_count_reg      <= '0;
            cq_head_reg       <= '0;
            cq_count_reg      <= '0;
            n_reg             <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            owner_present_reg <= owner_present_next;
            owner_id_reg      <= owner_id_next;
            spin_reg          <= spin_next;
            mq_head_reg       <= mq_head_next;
            mq_count_reg      <= mq_count_next;
            cq_head_reg       <= cq_head_next;
            cq_count_reg      <= cq_count_next;
            n_reg             <= n_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_tid_reg <= req_tid_next;
        m_res_reg   <= m_res_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (do_acq && acq_queue) begin
            mq_mem[mq_tail] <= acq_tid;
        end
    end

    always_ff @(posedge aclk) begin
        if (cq_push) begin
            cq_mem[cq_tail] <= head_req.tid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_res    = m_res_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- hw/rtl/fifo_handoff_mutex_condvar_top.sv -----
// top level of the lock manager for one mutex and one condition variable
// usage:
// requests enter on the s_ stream: op and thread id in s_tdata. results leave on the
// m_ stream, one or more per request, with m_tlast on the final result of each request.
// spin_floor and spin_ceiling are written through cfg_we, cfg_index and cfg_wdata
// while no request is in flight; a write takes effect at the same clock edge.
// a request passes through the decode register, the request queue and the result
// register before its first result shows on m_tvalid.
// throughput: the execution stage produces one result per cycle unless m_tready is low;
// lock, unlock, try lock and wake one give one result each, condition wait gives two
// and wake all gives one result per waiter it takes, up to sixteen. the front keeps accepting
// into a two-entry request queue while the execution stage is busy.
// reset clears ownership, both waiter queues and the request queue, sets the spin
// hint to 64 and the spin bounds to 16 and 512; waiter entries are not cleared.
// when the receiver holds m_tready low the result register holds its result, the
// execution stage stops, then the request queue and the front fill and s_tready drops.
module fifo_handoff_mutex_condvar_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [fhmc_pkg::IN_TDATA_W-1:0]       s_tdata,   // op, thread_id
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [fhmc_pkg::OUT_TDATA_W-1:0]      m_tdata,   // subject_thread, action,
                                                             // owner_valid, owner_thread,
                                                             // spin_hint, status
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [fhmc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [fhmc_pkg::SPIN_BITS-1:0]        cfg_wdata
);

    fhmc_pkg::cfg_t cfg_reg;
    fhmc_pkg::cfg_t cfg_next;
    logic           push;
    fhmc_pkg::req_t push_req;
    logic           fifo_full;
    logic           pop;
    logic           head_valid;
    fhmc_pkg::req_t head_req;
    fhmc_pkg::res_t m_res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                fhmc_pkg::CFG_SPIN_FLOOR:   cfg_next.spin_floor   = cfg_wdata;
                fhmc_pkg::CFG_SPIN_CEILING: cfg_next.spin_ceiling = cfg_wdata;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spin_floor   <= fhmc_pkg::SPIN_FLOOR_RESET;
            cfg_reg.spin_ceiling <= fhmc_pkg::SPIN_CEILING_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fhmc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_req  (push_req),
        .fifo_full (fifo_full)
    );

    fhmc_req_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_req   (push_req),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    fhmc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_res      (m_res),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = {{fhmc_pkg::OUT_PAD_W{1'b0}}, m_res};

endmodule

// ----- hw/rtl/fhmc_checker.sv -----
// port-level checker for the lock manager, bound to the top level
module fhmc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [fhmc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);

    fhmc_pkg::res_t res;

    assign res = m_tdata[$bits(fhmc_pkg::res_t)-1:0];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a grant leaves the subject as owner
    a_grant_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.action == fhmc_pkg::ACT_GRANTED |->
            res.owner_valid && res.owner_thread == res.subject_thread)
        else $error("grant without matching owner");

    // a free mutex reports no owner id
    a_free_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res.owner_valid |-> res.owner_thread == '0)
        else $error("owner id set on free mutex");

    // a release leaves the mutex free
    a_freed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.action == fhmc_pkg::ACT_FREED |-> !res.owner_valid)
        else $error("release left an owner");

    // a condition wait is always followed by its release result
    a_wait_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.action == fhmc_pkg::ACT_QCOND |-> !m_tlast && res.owner_valid)
        else $error("condition wait ended without release");

endmodule

bind fifo_handoff_mutex_condvar_top fhmc_checker u_fhmc_checker (.*);

// ----- tb/sv/fifo_handoff_mutex_condvar_top_tb.sv -----
// self-checking testbench for the mutex and condition variable lock manager
module fifo_handoff_mutex_condvar_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fhmc_pkg::*;

    localparam logic [OP_BITS-1:0] OP_BAD_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_BAD_7 = 3'd7;

    localparam int ITEMS_PER_PHASE = 61;
    localparam int N_DIR = 25;
    localparam int N_BOUNDS = 6;
    localparam int MAX_PRINTS = 30;

    localparam int MODE_MIX = 0;
    localparam int MODE_FILL = 1;
    localparam int MODE_DRAIN = 2;

    // cumulative cut points per mode: lock, owner unlock, try, owner wait, wake one, wake all, rest noise
    localparam int OP_CUTS [3][6] = '{
        '{30, 50, 60, 72, 82, 90},
        '{60, 65, 68, 93, 96, 98},
        '{10, 45, 50, 55, 75, 93}
    };
    localparam logic [OP_BITS-1:0] CAT_OP [6] = '{
        OP_LOCK, OP_UNLOCK, OP_TRY, OP_WAIT, OP_WAKE_ONE, OP_WAKE_ALL
    };

    localparam spin_t FLOOR_SET [N_BOUNDS] = '{10'd0, 10'd60, 10'd1023, 10'd0, 10'd1023, 10'd16};
    localparam spin_t CEIL_SET [N_BOUNDS] = '{10'd1023, 10'd68, 10'd0, 10'd0, 10'd1023, 10'd512};

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        tid_t               tid;
        logic               typed;
        action_t            act;
        status_t            st;
    } dir_row_t;

    typedef struct packed {
        res_t r;
        logic ends_request;
    } lock_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [IN_TDATA_W-1:0]         s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [OUT_TDATA_W-1:0]        m_tdata;
    logic                          m_tlast;
    logic                          cfg_we;
    logic [CFG_IDX_BITS-1:0]       cfg_index;
    logic [SPIN_BITS-1:0]          cfg_wdata;

    fifo_handoff_mutex_condvar_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    dir_row_t dir_rows [N_DIR] = '{
        '{OP_UNLOCK,    6'd5,  1'b1, ACT_REJECT,  STAT_UNLOCK_NOT_OWNER},
        '{OP_WAIT,      6'd5,  1'b1, ACT_REJECT,  STAT_WAIT_NOT_OWNER},
        '{OP_WAKE_ONE,  6'd0,  1'b1, ACT_NOBODY,  STAT_OK},
        '{OP_WAKE_ALL,  6'd63, 1'b1, ACT_NOBODY,  STAT_OK},
        '{OP_BAD_6,     6'd0,  1'b1, ACT_REJECT,  STAT_OK},
        '{OP_BAD_7,     6'd63, 1'b1, ACT_REJECT,  STAT_OK},
        '{OP_TRY,       6'd0,  1'b1, ACT_GRANTED, STAT_OK},
        '{OP_TRY,       6'd63, 1'b1, ACT_BUSY,    STAT_OK},
        '{OP_LOCK,      6'd0,  1'b1, ACT_QMUTEX,  STAT_OK},
        '{OP_LOCK,      6'd63, 1'b1, ACT_QMUTEX,  STAT_OK},
        '{OP_UNLOCK,    6'd63, 1'b1, ACT_REJECT,  STAT_UNLOCK_NOT_OWNER},
        '{OP_UNLOCK,    6'd0,  1'b0, ACT_GRANTED, STAT_OK},
        '{OP_WAIT,      6'd0,  1'b0, ACT_GRANTED, STAT_OK},
        '{OP_WAIT,      6'd63, 1'b0, ACT_GRANTED, STAT_OK},
        '{OP_WAKE_ONE,  6'd1,  1'b0, ACT_GRANTED, STAT_OK},
        '{OP_WAKE_ALL,  6'd2,  1'b0, ACT_GRANTED, STAT_OK},
        '{OP_UNLOCK,    6'd0,  1'b0, ACT_GRANTED, STAT_OK},
        '{OP_WAIT,      6'd63, 1'b0, ACT_GRANTED, STAT_OK},
        '{OP_LOCK,      6'd42, 1'b0, ACT_GRANTED, STAT_OK},
        '{OP_WAKE_ALL,  6'd42, 1'b0, ACT_GRANTED, STAT_OK},
        '{OP_UNLOCK,    6'd21, 1'b1, ACT_REJECT,  STAT_UNLOCK_NOT_OWNER},
        '{OP_UNLOCK,    6'd42, 1'b0, ACT_GRANTED, STAT_OK},
        '{OP_UNLOCK,    6'd63, 1'b0, ACT_GRANTED, STAT_OK},
        '{OP_LOCK,      6'd21, 1'b0, ACT_GRANTED, STAT_OK},
        '{OP_UNLOCK,    6'd21, 1'b0, ACT_GRANTED, STAT_OK}
    };

    // lock manager state as predicted
    logic  owner_held = 1'b0;
    tid_t  owner_tid = '0;
    spin_t spin_now = SPIN_RESET;
    spin_t floor_reg = SPIN_FLOOR_RESET;
    spin_t ceil_reg = SPIN_CEILING_RESET;
    tid_t  mwait [MQ_DEPTH];
    int    mhead = 0;
    int    mcount = 0;
    tid_t  cwait [CQ_DEPTH];
    int    chead = 0;
    int    ccount = 0;

    lock_result_t results_due [$];
    lock_result_t held;
    logic         held_v = 1'b0;
    res_t         first_res;
    int           batch_n;

    int mismatches = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_full = 0;
    int max_burst = 0;
    int send_calm = 0;
    int recv_calm = 0;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void emit(tid_t subj, action_t act, status_t st);
        lock_result_t e;
        e.r.subject_thread = subj;
        e.r.action = act;
        e.r.owner_valid = owner_held;
        e.r.owner_thread = owner_held ? owner_tid : '0;
        e.r.spin_hint = spin_now;
        e.r.status = st;
        e.ends_request = 1'b0;
        if (batch_n == 0)
            first_res = e.r;
        if (st == STAT_FULL)
            n_full++;
        if (held_v)
            results_due.push_back(held);
        held = e;
        held_v = 1'b1;
        batch_n++;
    endfunction

    function automatic action_t take_mutex(tid_t t, output status_t st);
        st = STAT_OK;
        if (!owner_held) begin
            owner_held = 1'b1;
            owner_tid = t;
            if (spin_now < ceil_reg)
                spin_now = spin_now + 1'b1;
            return ACT_GRANTED;
        end
        if (mcount >= MQ_DEPTH) begin
            st = STAT_FULL;
            return ACT_REJECT;
        end
        if (spin_now > floor_reg)
            spin_now = spin_now - 1'b1;
        mwait[(mhead + mcount) % MQ_DEPTH] = t;
        mcount++;
        return ACT_QMUTEX;
    endfunction

    function automatic void release_mutex(tid_t requester);
        tid_t w;
        if (mcount > 0) begin
            w = mwait[mhead];
            mhead = (mhead + 1) % MQ_DEPTH;
            mcount--;
            owner_held = 1'b1;
            owner_tid = w;
            emit(w, ACT_GRANTED, STAT_OK);
        end else begin
            owner_held = 1'b0;
            owner_tid = '0;
            emit(requester, ACT_FREED, STAT_OK);
        end
    endfunction

    function automatic logic wake_front();
        tid_t    w;
        action_t act;
        status_t st;
        w = cwait[chead];
        act = take_mutex(w, st);
        if (act != ACT_REJECT) begin
            chead = (chead + 1) % CQ_DEPTH;
            ccount--;
        end
        emit(w, act, st);
        return act != ACT_REJECT;
    endfunction

    function automatic void predict_request(logic [OP_BITS-1:0] op, tid_t t);
        logic    is_owner;
        action_t act;
        status_t st;
        batch_n = 0;
        is_owner = owner_held && owner_tid == t;
        case (op)
            OP_LOCK: begin
                act = take_mutex(t, st);
                emit(t, act, st);
            end
            OP_UNLOCK: begin
                if (!is_owner)
                    emit(t, ACT_REJECT, STAT_UNLOCK_NOT_OWNER);
                else
                    release_mutex(t);
            end
            OP_TRY: begin
                if (!owner_held) begin
                    owner_held = 1'b1;
                    owner_tid = t;
                    emit(t, ACT_GRANTED, STAT_OK);
                end else begin
                    emit(t, ACT_BUSY, STAT_OK);
                end
            end
            OP_WAIT: begin
                if (!is_owner) begin
                    emit(t, ACT_REJECT, STAT_WAIT_NOT_OWNER);
                end else if (ccount >= CQ_DEPTH) begin
                    emit(t, ACT_REJECT, STAT_FULL);
                end else begin
                    cwait[(chead + ccount) % CQ_DEPTH] = t;
                    ccount++;
                    emit(t, ACT_QCOND, STAT_OK);
                    release_mutex(t);
                end
            end
            OP_WAKE_ONE: begin
                if (ccount == 0)
                    emit(t, ACT_NOBODY, STAT_OK);
                else
                    void'(wake_front());
            end
            OP_WAKE_ALL: begin
                if (ccount == 0) begin
                    emit(t, ACT_NOBODY, STAT_OK);
                end else begin
                    while (ccount > 0 && batch_n < MAX_RESULTS) begin
                        if (!wake_front())
                            break;
                    end
                end
            end
            default: emit(t, ACT_REJECT, STAT_OK);
        endcase
        held.ends_request = 1'b1;
        results_due.push_back(held);
        held_v = 1'b0;
        if (batch_n > max_burst)
            max_burst = batch_n;
    endfunction

    // entered just after a falling edge, returns just after a falling edge
    task automatic send_request(logic [OP_BITS-1:0] op, tid_t t);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {{IN_PAD_W{1'b0}}, t, op};
        do @(posedge aclk); while (!s_tready);
        predict_request(op, t);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_bounds(spin_t lo, spin_t hi);
        wait_drained();
        cfg_we = 1'b1;
        cfg_index = CFG_SPIN_FLOOR;
        cfg_wdata = lo;
        @(negedge aclk);
        floor_reg = lo;
        cfg_index = CFG_SPIN_CEILING;
        cfg_wdata = hi;
        @(negedge aclk);
        ceil_reg = hi;
        cfg_we = 1'b0;
    endtask

    // segments of lock traffic: mixed, queue filling, queue draining
    task automatic random_requests(int count);
        int                 seg;
        int                 mode;
        int                 w;
        int                 k;
        logic [OP_BITS-1:0] op;
        tid_t               t;
        seg = 0;
        mode = MODE_FILL;
        for (int i = 0; i < count; i++) begin
            if (seg == 0) begin
                seg = $urandom_range(10, 40);
                if (i != 0)
                    mode = $urandom_range(MODE_MIX, MODE_DRAIN);
            end
            seg--;
            w = $urandom_range(0, 99);
            t = $urandom_range(0, 63);
            op = $urandom_range(0, 7);
            for (k = 0; k < 6; k++) begin
                if (w < OP_CUTS[mode][k])
                    break;
            end
            if (k < 6)
                op = CAT_OP[k];
            if (k < 6 && (op == OP_UNLOCK || op == OP_WAIT) && owner_held
                    && $urandom_range(0, 9) != 0)
                t = owner_tid;
            send_request(op, t);
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge aclk);
            w_gap: begin
                int lo;
                lo = pick_gap(recv_calm);
                if (lo > 0) begin
                    m_tready = 1'b0;
                    repeat (lo - 1) @(negedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        res_t         got;
        lock_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result with none expected, tdata %0h", m_tdata));
            end else begin
                want = results_due.pop_front();
                n_checked++;
                check_field("subject_thread", got.subject_thread, want.r.subject_thread);
                check_field("action", got.action, want.r.action);
                check_field("owner_valid", got.owner_valid, want.r.owner_valid);
                check_field("owner_thread", got.owner_thread, want.r.owner_thread);
                check_field("spin_hint", got.spin_hint, want.r.spin_hint);
                check_field("status", got.status, want.r.status);
                check_field("tlast", m_tlast, want.ends_request);
                check_field("tdata pad", m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W], '0);
            end
        end
    end

    initial begin
        #40ms;
        $display("timeout with %0d results outstanding", results_due.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SPIN_FLOOR;
        cfg_wdata = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            send_request(dir_rows[i].op, dir_rows[i].tid);
            if (dir_rows[i].typed && (first_res.action != dir_rows[i].act
                    || first_res.status != dir_rows[i].st))
                report_mismatch($sformatf("request %0d predicted action %0d status %0d",
                                          i, first_res.action, first_res.status));
        end

        random_requests(ITEMS_PER_PHASE);
        for (int p = 0; p < N_BOUNDS; p++) begin
            write_bounds(FLOOR_SET[p], CEIL_SET[p]);
            random_requests(ITEMS_PER_PHASE);
        end
        wait_drained();

        $display("%0d requests over %0d spin bound settings, %0d results checked",
                 n_sent, N_BOUNDS + 1, n_checked);
        $display("%0d full queue rejections, up to %0d results for one request",
                 n_full, max_burst);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
